// ----- design/bitmap_block_allocator_assert.svh -----
// Assertion macros for the bitmap block allocator.
// Plain text macros, no dependencies; included by the top level.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_block_allocator: assertion failed");

// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_block_allocator: assertion failed");

`endif

// ----- design/bba_pkg.sv -----
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by the interfaces, the allocator and the testbench.
package bba_pkg;

    localparam int BLK_IDX_W = 10;  // block_index field
    localparam int GRANT_W   = 9;   // granted_block field
    localparam int COUNT_W   = 10;  // used_count / free_count fields
    localparam int WORD_W    = 32;  // bitmap word width
    localparam int BIT_W     = 5;   // bit select within a word

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_TAKEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

// ----- design/bba_cmd_if.sv -----
// Command channel: valid/ready plus cmd and block_index.
// Depends on bba_pkg.
interface bba_cmd_if;
    import bba_pkg::*;

    logic                 valid;
    logic                 ready;
    t_cmd                 cmd;
    logic [BLK_IDX_W-1:0] block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

// ----- design/bba_rsp_if.sv -----
// Response channel: valid/ready plus status, grant and both counts.
// Depends on bba_pkg.
interface bba_rsp_if;
    import bba_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [GRANT_W-1:0] granted_block;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] free_count;

    modport source (output valid, output status, output granted_block,
                    output used_count, output free_count, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input used_count, input free_count, output ready);
endinterface

// ----- design/bba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- design/bitmap_block_allocator.sv -----
// bitmap_block_allocator: first-fit free-block allocator over a bitmap of
// NUM_BLOCKS blocks; uses bba_pkg, bba_cmd_if, bba_rsp_if, bba_ram and the
// assertion header. The bitmap lives in a RAM of 32-bit words with one
// flip-flop valid bit per word: a word never written reads as its reset
// pattern (reserved blocks RESERVED_START..RESERVED_START+RESERVED_COUNT-1
// set), so there is no clearing pass after reset and the block is ready at
// once. One command is worked at a time by a small sequencer around a single
// word-wide read/modify/compare unit; the used count is kept incrementally.
// Steps per command from accept to result load: query and out-of-range id
// go straight to the result state, request and release read and check one
// bitmap word, and allocate reads and checks word after word from word 0 until
// a clear bit is found or the last word is checked. A new command is accepted
// while a finished result still waits in the output register.
`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator #(
    parameter int NUM_BLOCKS     = 512,
    parameter int RESERVED_START = 127,
    parameter int RESERVED_COUNT = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bba_cmd_if.sink     i_cmd,
    bba_rsp_if.source   o_rsp
);
    import bba_pkg::*;

    // Geometry.
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    // Reserved blocks that actually lie inside the store.
    localparam int RES_END   = (RESERVED_START + RESERVED_COUNT < NUM_BLOCKS) ?
                               (RESERVED_START + RESERVED_COUNT) : NUM_BLOCKS;
    localparam int RES_INIT  = (RES_END > RESERVED_START) ? (RES_END - RESERVED_START) : 0;

    // Reset pattern of one bitmap word.
    function automatic logic [WORD_W-1:0] reset_word(input logic [WA_W-1:0] w);
        logic [WORD_W-1:0] v;
        int g;
        v = '0;
        for (int b = 0; b < WORD_W; b++) begin
            g = int'(w) * WORD_W + b;
            v[b] = (g >= RESERVED_START) && (g < RES_END);
        end
        return v;
    endfunction

    // Bits past the end of the store, seen as used by the search.
    function automatic logic [WORD_W-1:0] pad_mask(input logic [WA_W-1:0] w);
        logic [WORD_W-1:0] v;
        for (int b = 0; b < WORD_W; b++) begin
            v[b] = (int'(w) * WORD_W + b) >= NUM_BLOCKS;
        end
        return v;
    endfunction

    // Lowest clear bit of a word (caller checks that one exists).
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!v[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

    // Sequencer and working registers.
    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [BLK_IDX_W-1:0] r_id, n_id;
    logic [WA_W-1:0]      r_word, n_word;
    t_status              r_status, n_status;
    logic [GRANT_W-1:0]   r_grant, n_grant;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [NUM_WORDS-1:0] r_row_valid;

    // Output register.
    logic               r_rsp_valid;
    t_status            r_out_status;
    logic [GRANT_W-1:0] r_out_grant;
    logic [COUNT_W-1:0] r_out_used;
    logic [COUNT_W-1:0] r_out_free;

    // RAM port and datapath.
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] eff_word;     // stored word or its reset pattern
    logic [WORD_W-1:0] srch_word;    // with out-of-store bits forced used
    logic [WORD_W-1:0] bit_onehot;
    logic [BIT_W-1:0]  bit_sel;
    logic [BIT_W-1:0]  zero_idx;
    logic              id_in_range;
    logic [WA_W-1:0]   id_word;
    logic              cmd_ready;
    logic              load_rsp;

    logic [BLK_IDX_W+WA_W-1:0]       id_ext;
    logic [WA_W+BIT_W+GRANT_W-1:0]   grant_ext;
    logic [CNT_W-1:0]                free_cnt;
    logic [CNT_W+COUNT_W-1:0]        used_ext;
    logic [CNT_W+COUNT_W-1:0]        free_ext;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (r_word),
        .o_rdata (ram_rdata)
    );

    assign id_in_range = ({22'd0, i_cmd.block_index} < 32'(NUM_BLOCKS));
    assign id_ext      = {{WA_W{1'b0}}, i_cmd.block_index} >> BIT_W;
    assign id_word     = id_ext[WA_W-1:0];

    assign eff_word   = r_row_valid[r_word] ? ram_rdata : reset_word(r_word);
    assign srch_word  = eff_word | pad_mask(r_word);
    assign zero_idx   = first_zero(srch_word);
    assign bit_sel    = (r_cmd == CMD_ALLOC) ? zero_idx : r_id[BIT_W-1:0];
    assign bit_onehot = {{(WORD_W-1){1'b0}}, 1'b1} << bit_sel;
    assign grant_ext  = {{GRANT_W{1'b0}}, r_word, zero_idx};

    assign free_cnt = CNT_W'(NUM_BLOCKS) - r_used;
    assign used_ext = {{COUNT_W{1'b0}}, r_used};
    assign free_ext = {{COUNT_W{1'b0}}, free_cnt};

    // Next state and datapath control.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_word    = r_word;
        n_status  = r_status;
        n_grant   = r_grant;
        n_used    = r_used;
        ram_we    = 1'b0;
        ram_wdata = eff_word;
        cmd_ready = 1'b0;
        load_rsp  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.cmd;
                    n_id     = i_cmd.block_index;
                    n_status = ST_OK;
                    n_grant  = '0;
                    case (i_cmd.cmd)
                        CMD_ALLOC: begin
                            n_word  = '0;
                            n_state = S_READ;
                        end
                        CMD_REQUEST, CMD_RELEASE: begin
                            if (id_in_range) begin
                                n_word  = id_word;
                                n_state = S_READ;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_READ: begin
                // RAM read of r_word in flight
                n_state = S_CHECK;
            end

            S_CHECK: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (!(&srch_word)) begin
                            ram_we    = 1'b1;
                            ram_wdata = eff_word | bit_onehot;
                            n_used    = r_used + 1'b1;
                            n_grant   = grant_ext[GRANT_W-1:0];
                            n_state   = S_DONE;
                        end else if (r_word == WA_W'(NUM_WORDS - 1)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_word  = r_word + 1'b1;
                            n_state = S_READ;
                        end
                    end
                    CMD_REQUEST: begin
                        if ((eff_word & bit_onehot) != '0) begin
                            n_status = ST_TAKEN;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = eff_word | bit_onehot;
                            n_used    = r_used + 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        // release; freeing an already free block changes nothing
                        if ((eff_word & bit_onehot) != '0) begin
                            ram_we    = 1'b1;
                            ram_wdata = eff_word & ~bit_onehot;
                            n_used    = r_used - 1'b1;
                        end
                        n_state = S_DONE;
                    end
                endcase
            end

            S_DONE: begin
                // wait for the output register to be empty or drained
                if (!r_rsp_valid || o_rsp.ready) begin
                    load_rsp = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= CNT_W'(RES_INIT);
            r_row_valid <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (ram_we) begin
                r_row_valid[r_word] <= 1'b1;
            end
            if (load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_id     <= n_id;
        r_word   <= n_word;
        r_status <= n_status;
        r_grant  <= n_grant;
        if (load_rsp) begin
            r_out_status <= r_status;
            r_out_grant  <= r_grant;
            r_out_used   <= used_ext[COUNT_W-1:0];
            r_out_free   <= free_ext[COUNT_W-1:0];
        end
    end

    assign i_cmd.ready         = cmd_ready;
    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_block = r_out_grant;
    assign o_rsp.used_count    = r_out_used;
    assign o_rsp.free_count    = r_out_free;

    // Checks.
    `BBA_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(NUM_BLOCKS))
    `BBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, r_state != S_IDLE)
    `BBA_ASSERT_NOW(a_full_no_free, i_clk, i_rst_n, o_rsp.valid && o_rsp.status == ST_FULL, r_out_free == '0)
    `BBA_ASSERT_NOW(a_fail_no_grant, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != ST_OK, r_out_grant == '0)

endmodule

// ----- test/bitmap_block_allocator_test.sv -----
// Self-checking testbench for bitmap_block_allocator: directed table, then random traffic.
// Depends on bba_pkg, bba_cmd_if, bba_rsp_if and the allocator RTL; needs no files.
// Each response is checked against the table's typed values or an in-bench bitmap predictor.
module bitmap_block_allocator_test;
    import bba_pkg::*;

    // Same sizing as the block's defaults, passed down explicitly.
    localparam int NUM_BLK   = 512;
    localparam int RSV_START = 127;
    localparam int RSV_COUNT = 1;

    localparam int IDLE_MAX        = 12;    // per-transaction idle draw, both sides
    localparam int RANDOM_CMDS     = 1430;  // random part, after the directed table
    localparam int PRESSURE_AT     = 700;   // response count at which the sink holds off
    localparam int PRESSURE_CYCLES = 300;   // length of that hold-off
    localparam int DRAIN_CYCLES    = 80;    // wait for strays after the last owed response
    localparam int WDOG_LIMIT      = 2000;  // cycles with no transaction on either channel

    // Predicted response of one command.
    typedef struct packed {
        t_status              status;
        logic [GRANT_W-1:0]   grant;
        logic [COUNT_W-1:0]   used;
        logic [COUNT_W-1:0]   free;
    } t_alloc_rsp;

    // One row of the directed table. When typed is set the response columns
    // are the expected values; otherwise the predictor supplies them.
    typedef struct packed {
        t_cmd                 op;
        logic [BLK_IDX_W-1:0] idx;
        logic                 typed;
        t_alloc_rsp           rsp;
    } t_directed_row;

    // Traffic mix of the random part.
    typedef enum int {
        MIX_FILL,
        MIX_CHURN,
        MIX_DRAIN
    } t_mix;

    logic i_clk;
    logic i_rst_n;

    bba_cmd_if cmd_if ();
    bba_rsp_if rsp_if ();

    bitmap_block_allocator #(
        .NUM_BLOCKS     (NUM_BLK),
        .RESERVED_START (RSV_START),
        .RESERVED_COUNT (RSV_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Predictor state: one bit per block plus the running used count.
    bit          block_used [NUM_BLK];
    int unsigned used_total;

    t_alloc_rsp  pending_rsp_q [$];   // responses owed by the block, oldest first
    int          sent_count;
    int          rx_count = 0;
    int          error_count = 0;
    int          idle_cycles = 0;

    // Directed table: extremes of block_index, every command, reserved block,
    // word boundaries, release of a free block, and the range and taken error codes.
    t_directed_row directed_rows [0:22] = '{
        // after reset only the reserved block is used
        '{CMD_QUERY,   10'd0,    1'b1, '{ST_OK,    9'd0, 10'd1, 10'd511}},
        // lowest free block; index ignored by allocate
        '{CMD_ALLOC,   10'd1023, 1'b1, '{ST_OK,    9'd0, 10'd2, 10'd510}},
        '{CMD_REQUEST, 10'd1023, 1'b1, '{ST_RANGE, 9'd0, 10'd2, 10'd510}},
        '{CMD_RELEASE, 10'd512,  1'b1, '{ST_RANGE, 9'd0, 10'd2, 10'd510}},
        // reserved bitmap block starts out used
        '{CMD_REQUEST, 10'd127,  1'b1, '{ST_TAKEN, 9'd0, 10'd2, 10'd510}},
        // reserved block may be released, then released again while free
        '{CMD_RELEASE, 10'd127,  1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_RELEASE, 10'd127,  1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        // top block of the store
        '{CMD_REQUEST, 10'd511,  1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_REQUEST, 10'd511,  1'b1, '{ST_TAKEN, 9'd0, 10'd2, 10'd510}},
        '{CMD_RELEASE, 10'd511,  1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_REQUEST, 10'd0,    1'b1, '{ST_TAKEN, 9'd0, 10'd1, 10'd511}},
        '{CMD_ALLOC,   10'd0,    1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_REQUEST, 10'd127,  1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        // a hole below used blocks is found first
        '{CMD_RELEASE, 10'd0,    1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_ALLOC,   10'd0,    1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_QUERY,   10'd1023, 1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_ALLOC,   10'd0,    1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_RELEASE, 10'd1023, 1'b1, '{ST_RANGE, 9'd0, 10'd4, 10'd508}},
        '{CMD_REQUEST, 10'd512,  1'b1, '{ST_RANGE, 9'd0, 10'd4, 10'd508}},
        // both sides of the first bitmap word boundary
        '{CMD_REQUEST, 10'd31,   1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_REQUEST, 10'd32,   1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_RELEASE, 10'd2,    1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}},
        '{CMD_ALLOC,   10'd0,    1'b0, '{ST_OK,    9'd0, 10'd0, 10'd0}}
    };

    // Free-running clock, period 8.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bitmap state after reset: reserved blocks that fall inside the store.
    function automatic void reset_bitmap();
        int id;
        for (int k = 0; k < NUM_BLK; k++) block_used[k] = 1'b0;
        used_total = 0;
        for (int k = 0; k < RSV_COUNT; k++) begin
            id = RSV_START + k;
            if (id < NUM_BLK && !block_used[id]) begin
                block_used[id] = 1'b1;
                used_total++;
            end
        end
    endfunction

    // Applies one command to the bitmap and returns the response it owes.
    function automatic t_alloc_rsp apply_command(t_cmd op, logic [BLK_IDX_W-1:0] idx);
        t_alloc_rsp  r;
        bit          found;
        int unsigned free_blocks;
        r.status = ST_OK;
        r.grant  = '0;
        found    = 1'b0;
        case (op)
            CMD_ALLOC: begin
                // first fit: lowest clear bit wins
                for (int k = 0; k < NUM_BLK && !found; k++) begin
                    if (!block_used[k]) begin
                        block_used[k] = 1'b1;
                        used_total++;
                        r.grant = k[GRANT_W-1:0];
                        found   = 1'b1;
                    end
                end
                if (!found) r.status = ST_FULL;
            end
            CMD_REQUEST: begin
                if (idx >= NUM_BLK) begin
                    r.status = ST_RANGE;
                end else if (block_used[idx]) begin
                    r.status = ST_TAKEN;
                end else begin
                    block_used[idx] = 1'b1;
                    used_total++;
                end
            end
            CMD_RELEASE: begin
                // releasing a free block is a no-op that still answers OK
                if (idx >= NUM_BLK) begin
                    r.status = ST_RANGE;
                end else if (block_used[idx]) begin
                    block_used[idx] = 1'b0;
                    used_total--;
                end
            end
            default: ;
        endcase
        free_blocks = NUM_BLK - used_total;
        r.used = used_total[COUNT_W-1:0];
        r.free = free_blocks[COUNT_W-1:0];
        return r;
    endfunction

    // Block id for request/release: some out of range; releases lean toward
    // used blocks so that they actually free something.
    function automatic logic [BLK_IDX_W-1:0] pick_block(bit want_used);
        int id;
        if ($urandom_range(0, 99) < 15) return BLK_IDX_W'($urandom_range(NUM_BLK, 1023));
        id = $urandom_range(0, NUM_BLK - 1);
        for (int t = 0; t < 4 && want_used && !block_used[id]; t++)
            id = $urandom_range(0, NUM_BLK - 1);
        return BLK_IDX_W'(id);
    endfunction

    // Random command n. A long fill run first drives the store to full, then
    // windows of churn (near full), drain and refill follow in turn.
    task automatic draw_command(input int n, output t_cmd op,
                                output logic [BLK_IDX_W-1:0] idx);
        t_mix mix;
        int   roll;
        int   alloc_pct;
        int   req_pct;
        int   rel_pct;
        if (n < 640) begin
            mix = MIX_FILL;
        end else begin
            case (((n - 640) / 160) % 3)
                0:       mix = MIX_CHURN;
                1:       mix = MIX_DRAIN;
                default: mix = MIX_FILL;
            endcase
        end
        case (mix)
            MIX_FILL: begin
                alloc_pct = 78; req_pct = 10; rel_pct = 5;
            end
            MIX_CHURN: begin
                alloc_pct = 45; req_pct = 10; rel_pct = 35;
            end
            default: begin
                alloc_pct = 15; req_pct = 5; rel_pct = 70;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            op  = CMD_ALLOC;
            idx = BLK_IDX_W'($urandom_range(0, 1023));
        end else if (roll < alloc_pct + req_pct) begin
            op  = CMD_REQUEST;
            idx = pick_block(1'b0);
        end else if (roll < alloc_pct + req_pct + rel_pct) begin
            op  = CMD_RELEASE;
            idx = pick_block(1'b1);
        end else begin
            op  = CMD_QUERY;
            idx = BLK_IDX_W'($urandom_range(0, 1023));
        end
    endtask

    // Idle draw for one transaction; every fourth run of 64 has no idling.
    function automatic int idle_draw(int n);
        if ((n / 64) % 4 == 1) return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    // Offers one command and waits for its transaction. The owed response is
    // queued at the accepting edge: the typed one for checked table rows,
    // else the predictor's. The predictor state advances either way.
    task automatic send_command(input t_cmd op, input logic [BLK_IDX_W-1:0] idx,
                                input logic typed, input t_alloc_rsp typed_rsp);
        int         gap;
        t_alloc_rsp predicted;
        gap = idle_draw(sent_count);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.cmd         <= op;
        cmd_if.block_index <= idx;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = apply_command(op, idx);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
        sent_count++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on response %0d, %s: got %0d expected %0d",
                 rx_count, what, got, want);
        error_count++;
    endtask

    // Compares the response of this edge's transaction with the oldest owed one.
    task automatic check_response();
        t_alloc_rsp want;
        if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response, used_count", rsp_if.used_count, 0);
            return;
        end
        want = pending_rsp_q.pop_front();
        if (rsp_if.status !== want.status)
            report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.granted_block !== want.grant)
            report_mismatch("granted_block", rsp_if.granted_block, want.grant);
        if (rsp_if.used_count !== want.used)
            report_mismatch("used_count", rsp_if.used_count, want.used);
        if (rsp_if.free_count !== want.free)
            report_mismatch("free_count", rsp_if.free_count, want.free);
    endtask

    // Response side: random stalls, plus one long hold-off so that the
    // output register and the sequencer fill and the command side backs up.
    initial begin
        int gap;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_draw(rx_count);
            if (rx_count == PRESSURE_AT) gap = PRESSURE_CYCLES;
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            check_response();
            rx_count++;
        end
    end

    // Cycles since the last transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        wait (idle_cycles >= WDOG_LIMIT);
        $display("bitmap_block_allocator_test NOT OK");
        $finish;
    end

    // Command side and end of run.
    initial begin
        t_cmd                 op;
        logic [BLK_IDX_W-1:0] idx;
        sent_count         = 0;
        i_rst_n            <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.cmd         <= CMD_QUERY;
        cmd_if.block_index <= '0;
        reset_bitmap();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_command(directed_rows[r].op, directed_rows[r].idx,
                         directed_rows[r].typed, directed_rows[r].rsp);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            draw_command(n, op, idx);
            send_command(op, idx, 1'b0, '0);
        end

        // let every owed response arrive, then watch for strays
        @(posedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("bitmap_block_allocator_test OK");
        end else begin
            $display("bitmap_block_allocator_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/bba_pkg.sv
design/bba_cmd_if.sv
design/bba_rsp_if.sv
design/bba_ram.sv
design/bitmap_block_allocator.sv
test/bitmap_block_allocator_test.sv
